/* rtl/core/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared codes and types for the first-fit heap allocator core.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_FAILED  = 2'd1;
    localparam logic [1:0] STAT_IGNORED = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_SPLIT_WR,
        S_TAIL_RD,
        S_TAIL_WR,
        S_REL_CHK,
        S_MRG_CHK,
        S_MRG_WR,
        S_DONE
    } t_state;

endpackage

/* rtl/core/ffha_req_if.sv */
// ----------------------------------------------------------------------------
// ffha_req_if
// Request channel of the allocator: operation, size and release address.
// ----------------------------------------------------------------------------
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [16:0] request_size;
    logic [31:0] release_address;

    modport source (output valid, operation, request_size, release_address, input ready);
    modport sink   (input valid, operation, request_size, release_address, output ready);
endinterface

/* rtl/core/ffha_rsp_if.sv */
// ----------------------------------------------------------------------------
// ffha_rsp_if
// Response channel of the allocator: granted address and status.
// ----------------------------------------------------------------------------
interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] payload_address;
    logic [1:0]  status;

    modport source (output valid, payload_address, status, input ready);
    modport sink   (input valid, payload_address, status, output ready);
endinterface

/* rtl/core/ffha_hdr_ram.sv */
// ----------------------------------------------------------------------------
// ffha_hdr_ram
// Single-port header store, one header per 16-byte slot, registered read.
// ----------------------------------------------------------------------------
module ffha_hdr_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ffha_ctrl.sv */
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for the allocator: walks the block chain one header per cycle,
// splits, appends and merges blocks, and holds the response register.
// ----------------------------------------------------------------------------
module ffha_ctrl
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES      = 65536,
    parameter int HEADER_BYTES    = 16,
    parameter int MIN_SPLIT_SLACK = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_base,
    ffha_req_if.sink    i_req,
    ffha_rsp_if.source  o_rsp
);

    localparam int SLOTS    = (HEAP_BYTES + 15) / 16;
    localparam int HS       = (HEADER_BYTES + 15) / 16;
    localparam int HDR_SPAN = HS * 16;
    localparam int IW       = $clog2(SLOTS);
    localparam int SW       = $clog2(SLOTS + 1);
    localparam int NW       = 13;
    localparam int CW       = ((SW > NW) ? SW : NW) + 2;
    localparam int HW       = 3 + SW + IW;

    t_state r_state, n_state;

    logic          r_op;
    logic          r_zero;
    logic [NW-1:0] r_need;
    logic [31:0]   r_raddr;
    logic [IW-1:0] r_cur, n_cur;
    logic [IW-1:0] r_ns, n_ns;
    logic [SW-1:0] r_hsize, n_hsize;
    logic          r_hnext_v, n_hnext_v;
    logic [IW-1:0] r_hnext, n_hnext;
    logic [SW-1:0] r_brk, n_brk;
    logic          r_chain, n_chain;
    logic [IW-1:0] r_tail, n_tail;
    logic [IW-1:0] r_clr, n_clr;
    logic [31:0]   r_res_addr, n_res_addr;
    logic [1:0]    r_res_stat, n_res_stat;
    logic          r_out_valid;
    logic [31:0]   r_out_addr;
    logic [1:0]    r_out_stat;

    logic          mem_we, mem_re;
    logic [IW-1:0] mem_addr;
    logic [HW-1:0] mem_wdata, mem_rdata;

    ffha_hdr_ram #(.DEPTH(SLOTS), .AW(IW), .DW(HW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    function automatic logic [HW-1:0] pack(input logic v, input logic f, input logic hn,
                                           input logic [SW-1:0] sz, input logic [IW-1:0] nx);
        pack = {v, f, hn, sz, nx};
    endfunction

    function automatic logic [31:0] payload(input logic [31:0] base, input logic [IW-1:0] s);
        payload = base + (32'(s) << 4) + 32'(HDR_SPAN);
    endfunction

    // Fields of the header read in the previous cycle.
    logic          rd_valid, rd_free, rd_hn;
    logic [SW-1:0] rd_size;
    logic [IW-1:0] rd_next;
    assign rd_valid = mem_rdata[HW-1];
    assign rd_free  = mem_rdata[HW-2];
    assign rd_hn    = mem_rdata[HW-3];
    assign rd_size  = mem_rdata[IW +: SW];
    assign rd_next  = mem_rdata[IW-1:0];

    logic [CW-1:0] total;
    logic          first_fail;
    logic [31:0]   rel_off;
    logic [IW-1:0] rel_slot;
    logic          rel_bad;
    logic          fit, split, walk_end, app_fail, merge_ok;
    logic [SW-1:0] leftover;
    logic [CW-1:0] ns_c;

    assign total      = CW'(r_need) + CW'(HS);
    assign first_fail = total > CW'(SLOTS);
    assign rel_off    = r_raddr - i_base - 32'(HDR_SPAN);
    assign rel_slot   = rel_off[IW+3:4];
    assign rel_bad    = (r_raddr == 32'd0) || !r_chain
                        || (rel_off >= 32'(HEAP_BYTES)) || (rel_off[3:0] != 4'd0)
                        || (SW'(rel_slot) >= r_brk);
    assign fit        = rd_free && (CW'(rd_size) >= CW'(r_need));
    assign leftover   = rd_size - SW'(r_need);
    assign ns_c       = CW'(r_cur) + total;
    assign split      = ((32'(leftover) << 4) > 32'(HDR_SPAN + MIN_SPLIT_SLACK))
                        && (ns_c < CW'(SLOTS));
    assign walk_end   = !rd_hn || (CW'(rd_next) >= CW'(SLOTS));
    assign app_fail   = (CW'(r_brk) + total) > CW'(SLOTS);
    assign merge_ok   = rd_hn && (CW'(rd_next) < CW'(SLOTS)) && (SW'(rd_next) < r_brk);

    assign i_req.ready = (r_state == S_IDLE);
    logic out_load;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == IW'(SLOTS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (r_op == OP_ALLOC) begin
                    if (r_zero || !r_chain) n_state = S_DONE;
                    else n_state = S_WALK;
                end else begin
                    n_state = rel_bad ? S_DONE : S_REL_CHK;
                end
            end
            S_WALK: begin
                if (fit) n_state = split ? S_SPLIT_WR : S_DONE;
                else if (walk_end) n_state = app_fail ? S_DONE : S_TAIL_RD;
            end
            S_SPLIT_WR: n_state = S_DONE;
            S_TAIL_RD:  n_state = S_TAIL_WR;
            S_TAIL_WR:  n_state = S_DONE;
            S_REL_CHK: begin
                if (rd_valid && !rd_free && merge_ok) n_state = S_MRG_CHK;
                else n_state = S_DONE;
            end
            S_MRG_CHK: n_state = (rd_valid && rd_free) ? S_MRG_WR : S_DONE;
            S_MRG_WR:  n_state = S_DONE;
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = r_cur;
        mem_wdata  = pack(1'b1, 1'b1, r_hnext_v, r_hsize, r_hnext);
        n_cur      = r_cur;
        n_ns       = r_ns;
        n_hsize    = r_hsize;
        n_hnext_v  = r_hnext_v;
        n_hnext    = r_hnext;
        n_brk      = r_brk;
        n_chain    = r_chain;
        n_tail     = r_tail;
        n_clr      = r_clr;
        n_res_addr = r_res_addr;
        n_res_stat = r_res_stat;
        case (r_state)
            S_CLEAR: begin
                // After reset every header is marked not valid, one slot per cycle.
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
            end
            S_DECODE: begin
                n_res_addr = 32'd0;
                if (r_op == OP_ALLOC) begin
                    if (r_zero) begin
                        n_res_stat = STAT_FAILED;
                    end else if (!r_chain) begin
                        if (first_fail) begin
                            n_res_stat = STAT_FAILED;
                        end else begin
                            mem_we     = 1'b1;
                            mem_addr   = '0;
                            mem_wdata  = pack(1'b1, 1'b0, 1'b0, SW'(r_need), '0);
                            n_chain    = 1'b1;
                            n_tail     = '0;
                            n_brk      = SW'(total);
                            n_res_addr = payload(i_base, '0);
                            n_res_stat = STAT_DONE;
                        end
                    end else begin
                        mem_re   = 1'b1;
                        mem_addr = '0;
                        n_cur    = '0;
                    end
                end else begin
                    n_res_stat = STAT_IGNORED;
                    if (!rel_bad) begin
                        mem_re   = 1'b1;
                        mem_addr = rel_slot;
                        n_cur    = rel_slot;
                    end
                end
            end
            S_WALK: begin
                if (fit) begin
                    if (split) begin
                        mem_we    = 1'b1;
                        mem_addr  = IW'(ns_c);
                        mem_wdata = pack(1'b1, 1'b1, rd_hn, leftover - SW'(HS), rd_next);
                        n_ns      = IW'(ns_c);
                    end else begin
                        mem_we     = 1'b1;
                        mem_addr   = r_cur;
                        mem_wdata  = pack(1'b1, 1'b0, rd_hn, rd_size, rd_next);
                        n_res_addr = payload(i_base, r_cur);
                        n_res_stat = STAT_DONE;
                    end
                end else if (walk_end) begin
                    if (app_fail) begin
                        n_res_addr = 32'd0;
                        n_res_stat = STAT_FAILED;
                    end else begin
                        mem_we    = 1'b1;
                        mem_addr  = IW'(r_brk);
                        mem_wdata = pack(1'b1, 1'b0, 1'b0, SW'(r_need), '0);
                        n_ns      = IW'(r_brk);
                    end
                end else begin
                    mem_re   = 1'b1;
                    mem_addr = rd_next;
                    n_cur    = rd_next;
                end
            end
            S_SPLIT_WR: begin
                mem_we     = 1'b1;
                mem_addr   = r_cur;
                mem_wdata  = pack(1'b1, 1'b0, 1'b1, SW'(r_need), r_ns);
                if (r_tail == r_cur) n_tail = r_ns;
                n_res_addr = payload(i_base, r_cur);
                n_res_stat = STAT_DONE;
            end
            S_TAIL_RD: begin
                mem_re   = 1'b1;
                mem_addr = r_tail;
            end
            S_TAIL_WR: begin
                mem_we     = 1'b1;
                mem_addr   = r_tail;
                mem_wdata  = pack(rd_valid, rd_free, 1'b1, rd_size, r_ns);
                n_tail     = r_ns;
                n_brk      = SW'(CW'(r_brk) + total);
                n_res_addr = payload(i_base, r_ns);
                n_res_stat = STAT_DONE;
            end
            S_REL_CHK: begin
                n_hsize   = rd_size;
                n_hnext_v = rd_hn;
                n_hnext   = rd_next;
                if (rd_valid && !rd_free) begin
                    n_res_stat = STAT_DONE;
                    if (merge_ok) begin
                        mem_re   = 1'b1;
                        mem_addr = rd_next;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = pack(1'b1, 1'b1, rd_hn, rd_size, rd_next);
                    end
                end
            end
            S_MRG_CHK: begin
                if (rd_valid && rd_free) begin
                    // The successor is absorbed: retire its header first.
                    mem_we    = 1'b1;
                    mem_addr  = r_hnext;
                    mem_wdata = pack(1'b0, rd_free, rd_hn, rd_size, rd_next);
                    n_hsize   = r_hsize + SW'(HS) + rd_size;
                    n_hnext_v = rd_hn;
                    n_hnext   = rd_next;
                    if (r_tail == r_hnext) n_tail = r_cur;
                end else begin
                    mem_we = 1'b1;
                end
            end
            S_MRG_WR: begin
                mem_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_brk       <= '0;
            r_chain     <= 1'b0;
            r_tail      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_brk   <= n_brk;
            r_chain <= n_chain;
            r_tail  <= n_tail;
            r_clr   <= n_clr;
            if (out_load) r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_op    <= i_req.operation;
            r_zero  <= (i_req.request_size == 17'd0);
            r_need  <= NW'((18'(i_req.request_size) + 18'd15) >> 4);
            r_raddr <= i_req.release_address;
        end
        r_cur      <= n_cur;
        r_ns       <= n_ns;
        r_hsize    <= n_hsize;
        r_hnext_v  <= n_hnext_v;
        r_hnext    <= n_hnext;
        r_res_addr <= n_res_addr;
        r_res_stat <= n_res_stat;
        if (out_load) begin
            r_out_addr <= r_res_addr;
            r_out_stat <= r_res_stat;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.payload_address = r_out_addr;
    assign o_rsp.status          = r_out_stat;

endmodule

/* rtl/core/first_fit_heap_allocator_core.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// A size-zero or first allocate is answered from decode; other allocates walk the
// chain header by header, then split the fit or read and link the tail to append.
// A release checks its header and may merge the next block. One request at a time,
// bound by the single header memory port. Reset (synchronous, active low) empties the
// chain, zeroes the break, sets the base to 0x100000 and clears every header, request side idle.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES      = 65536,
    parameter int HEADER_BYTES    = 16,
    parameter int MIN_SPLIT_SLACK = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    ffha_req_if.sink    i_req,
    ffha_rsp_if.source  o_rsp
);

    logic [31:0] r_base_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_addr <= 32'h0010_0000;
        end else if (i_cfg_we) begin
            r_base_addr <= i_cfg_wdata;
        end
    end

    ffha_ctrl #(
        .HEAP_BYTES      (HEAP_BYTES),
        .HEADER_BYTES    (HEADER_BYTES),
        .MIN_SPLIT_SLACK (MIN_SPLIT_SLACK)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_base  (r_base_addr),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

/* tb/sv/tb_first_fit_heap_allocator_core.sv */
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_core
// Self-checking bench for the first-fit heap allocator: a directed table of
// requests, then random allocate/release traffic over several heap bases and
// idle patterns, each response checked against a behavioural heap model.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_core;
    import ffha_pkg::*;

    localparam int SLOT_COUNT  = 4096;
    localparam int HEAP_LEN    = 65536;
    localparam int HDR_SPAN    = 16;
    localparam int SPLIT_SLACK = 8;
    localparam int STALL_LIMIT = 40000;
    localparam int PHASE_ITEMS = 325;

    typedef struct {
        logic        op;
        logic [16:0] size;
        logic [31:0] addr;
        bit          typed;
        logic [31:0] exp_addr;
        logic [1:0]  exp_status;
    } t_dir_row;

    typedef struct {
        logic [31:0] addr;
        logic [1:0]  status;
    } t_grant;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    ffha_req_if req_if();
    ffha_rsp_if rsp_if();

    first_fit_heap_allocator_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    // Heap model state.
    bit          hdr_valid [SLOT_COUNT];
    bit          hdr_free  [SLOT_COUNT];
    bit          hdr_more  [SLOT_COUNT];
    int          hdr_size  [SLOT_COUNT];
    int          hdr_next  [SLOT_COUNT];
    int          break_ofs;
    bit          chain_up;
    int          tail_idx;
    logic [31:0] cur_base;

    t_grant      pending_grants[$];
    int          live_slots[$];
    int          freed_slots[$];
    t_dir_row    dir_rows[$];
    int          error_count = 0;
    int          sender_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;

    function automatic logic [31:0] slot_payload(int slot);
        return cur_base + 32'(slot * 16) + 32'(HDR_SPAN);
    endfunction

    function automatic t_grant heap_allocate(logic [16:0] size);
        t_grant g;
        int need, total, cur, left, ns;
        g.addr = '0;
        g.status = STAT_FAILED;
        if (size == 0) return g;
        need = (int'(size) + 15) & ~15;
        total = HDR_SPAN + need;
        if (!chain_up) begin
            if (total > HEAP_LEN) return g;
            hdr_valid[0] = 1; hdr_free[0] = 0; hdr_more[0] = 0;
            hdr_next[0] = 0; hdr_size[0] = need;
            chain_up = 1; tail_idx = 0; break_ofs = total;
            g.addr = slot_payload(0);
            g.status = STAT_DONE;
            return g;
        end
        cur = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (hdr_free[cur] && hdr_size[cur] >= need) begin
                left = hdr_size[cur] - need;
                if (left > HDR_SPAN + SPLIT_SLACK) begin
                    ns = cur + total / 16;
                    if (ns < SLOT_COUNT) begin
                        hdr_valid[ns] = 1; hdr_free[ns] = 1;
                        hdr_size[ns] = left - HDR_SPAN;
                        hdr_more[ns] = hdr_more[cur];
                        hdr_next[ns] = hdr_next[cur];
                        hdr_size[cur] = need;
                        hdr_more[cur] = 1;
                        hdr_next[cur] = ns;
                        if (tail_idx == cur) tail_idx = ns;
                    end
                end
                hdr_free[cur] = 0;
                g.addr = slot_payload(cur);
                g.status = STAT_DONE;
                return g;
            end
            if (!hdr_more[cur] || hdr_next[cur] >= SLOT_COUNT) break;
            cur = hdr_next[cur];
        end
        if (break_ofs + total > HEAP_LEN || (break_ofs & 15) != 0) return g;
        ns = break_ofs / 16;
        hdr_valid[ns] = 1; hdr_free[ns] = 0; hdr_more[ns] = 0;
        hdr_next[ns] = 0; hdr_size[ns] = need;
        hdr_more[tail_idx] = 1;
        hdr_next[tail_idx] = ns;
        tail_idx = ns;
        break_ofs += total;
        g.addr = slot_payload(ns);
        g.status = STAT_DONE;
        return g;
    endfunction

    function automatic t_grant heap_release(logic [31:0] addr);
        t_grant g;
        logic [31:0] ofs;
        int slot, nb;
        g.addr = '0;
        g.status = STAT_IGNORED;
        if (addr == 0 || !chain_up) return g;
        ofs = addr - cur_base - 32'(HDR_SPAN);
        if (ofs >= 32'(HEAP_LEN) || ofs[3:0] != 0) return g;
        slot = int'(ofs >> 4);
        if (!hdr_valid[slot] || hdr_free[slot]) return g;
        hdr_free[slot] = 1;
        if (hdr_more[slot] && hdr_next[slot] < SLOT_COUNT) begin
            nb = hdr_next[slot];
            if (hdr_valid[nb] && hdr_free[nb]) begin
                if (tail_idx == nb) tail_idx = slot;
                hdr_size[slot] += HDR_SPAN + hdr_size[nb];
                hdr_more[slot] = hdr_more[nb];
                hdr_next[slot] = hdr_next[nb];
                hdr_valid[nb] = 0;
            end
        end
        g.status = STAT_DONE;
        return g;
    endfunction

    // Runs one accepted request through the model and keeps the lists of
    // live and freed blocks that the random traffic draws on.
    task automatic record_request(logic op, logic [16:0] size, logic [31:0] addr,
                                  bit typed, t_grant typed_grant);
        t_grant g;
        int slot;
        if (op == OP_ALLOC) begin
            g = heap_allocate(size);
            if (g.status == STAT_DONE) live_slots.push_back(int'((g.addr - cur_base) >> 4) - 1);
        end else begin
            g = heap_release(addr);
            if (g.status == STAT_DONE) begin
                slot = int'((addr - cur_base) >> 4) - 1;
                foreach (live_slots[k]) begin
                    if (live_slots[k] == slot) begin
                        live_slots.delete(k);
                        break;
                    end
                end
                freed_slots.push_back(slot);
                if (freed_slots.size() > 64) void'(freed_slots.pop_front());
            end
        end
        pending_grants.push_back(typed ? typed_grant : g);
    endtask

    task automatic send_request(logic op, logic [16:0] size, logic [31:0] addr,
                                bit typed, t_grant typed_grant);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid           <= 1'b1;
        req_if.operation       <= op;
        req_if.request_size    <= size;
        req_if.release_address <= addr;
        do @(posedge i_clk); while (!req_if.ready);
        record_request(op, size, addr, typed, typed_grant);
    endtask

    task automatic add_row(logic op, logic [16:0] size, logic [31:0] addr, bit typed,
                           logic [31:0] exp_addr, logic [1:0] exp_status);
        t_dir_row r;
        r.op = op; r.size = size; r.addr = addr; r.typed = typed;
        r.exp_addr = exp_addr; r.exp_status = exp_status;
        dir_rows.push_back(r);
    endtask

    task automatic drain_and_configure(logic [31:0] base);
        req_if.valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        cur_base = base;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [16:0] random_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return 17'($urandom_range(256, 1));
        if (pick < 90) return 17'($urandom_range(4096, 257));
        if (pick < 98) return 17'($urandom_range(65536, 0));
        return pick[0] ? 17'd65536 : 17'd0;
    endfunction

    function automatic logic [31:0] random_release_addr();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55 && live_slots.size() != 0)
            return slot_payload(live_slots[$urandom_range(live_slots.size() - 1)]);
        if (pick < 70 && freed_slots.size() != 0)
            return slot_payload(freed_slots[$urandom_range(freed_slots.size() - 1)]);
        if (pick < 78) return '0;
        if (pick < 88) return slot_payload($urandom_range(SLOT_COUNT - 1))
                              + 32'($urandom_range(15));
        return $urandom();
    endfunction

    // Response side: random back-pressure and in-order checking.
    always @(posedge i_clk) begin
        t_grant g;
        if (rsp_if.valid && rsp_if.ready) begin
            if (pending_grants.size() == 0) begin
                $display("%0t: response with none expected: addr %h status %0d",
                         $time, rsp_if.payload_address, rsp_if.status);
                error_count++;
            end else begin
                g = pending_grants.pop_front();
                if (rsp_if.payload_address !== g.addr) begin
                    $display("%0t: payload_address expected %h actual %h",
                             $time, g.addr, rsp_if.payload_address);
                    error_count++;
                end
                if (rsp_if.status !== g.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, g.status, rsp_if.status);
                    error_count++;
                end
            end
        end
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (i_rst_n) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_first_fit_heap_allocator_core NOT OK");
                $finish;
            end
        end
    end

    initial begin
        t_grant tg;
        logic [31:0] bases[4];
        int idle_pcts[4];
        int stall_pcts[4];
        logic op;

        req_if.valid = 1'b0;
        req_if.operation = OP_ALLOC;
        req_if.request_size = '0;
        req_if.release_address = '0;
        rsp_if.ready = 1'b0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            hdr_valid[s] = 0; hdr_free[s] = 0; hdr_more[s] = 0;
            hdr_size[s] = 0; hdr_next[s] = 0;
        end
        break_ofs = 0; chain_up = 0; tail_idx = 0;
        cur_base = 32'h0010_0000;

        // Fresh heap at the reset base, then first-fit reuse, splits and merges.
        add_row(OP_ALLOC,   17'd0,     32'h0,         1, 32'h0,         STAT_FAILED);
        add_row(OP_ALLOC,   17'd65536, 32'hFFFF_FFFF, 1, 32'h0,         STAT_FAILED);
        add_row(OP_RELEASE, 17'h1FFFF, 32'h0,         1, 32'h0,         STAT_IGNORED);
        add_row(OP_RELEASE, 17'd0,     32'h0010_0010, 1, 32'h0,         STAT_IGNORED);
        add_row(OP_ALLOC,   17'd1,     32'h0,         1, 32'h0010_0010, STAT_DONE);
        add_row(OP_ALLOC,   17'd16,    32'h0,         0, 32'h0,         STAT_DONE);
        add_row(OP_ALLOC,   17'd17,    32'h0,         0, 32'h0,         STAT_DONE);
        add_row(OP_RELEASE, 17'd0,     32'h0010_0030, 0, 32'h0,         STAT_DONE);
        add_row(OP_RELEASE, 17'd0,     32'h0010_0010, 0, 32'h0,         STAT_DONE);
        add_row(OP_RELEASE, 17'd0,     32'h0010_0030, 0, 32'h0,         STAT_DONE);
        add_row(OP_RELEASE, 17'd0,     32'h0010_0010, 0, 32'h0,         STAT_DONE);
        add_row(OP_ALLOC,   17'd8,     32'h0,         0, 32'h0,         STAT_DONE);
        add_row(OP_ALLOC,   17'd65520, 32'h0,         1, 32'h0,         STAT_FAILED);
        add_row(OP_RELEASE, 17'd0,     32'h0010_0018, 1, 32'h0,         STAT_IGNORED);
        add_row(OP_RELEASE, 17'd0,     32'h0011_0010, 1, 32'h0,         STAT_IGNORED);
        add_row(OP_RELEASE, 17'd0,     32'h000F_FFF0, 1, 32'h0,         STAT_IGNORED);
        add_row(OP_ALLOC,   17'd16,    32'h0,         0, 32'h0,         STAT_DONE);
        add_row(OP_ALLOC,   17'd48,    32'h0,         0, 32'h0,         STAT_DONE);
        add_row(OP_RELEASE, 17'd0,     32'h0010_0050, 0, 32'h0,         STAT_DONE);
        add_row(OP_ALLOC,   17'd30000, 32'h0,         0, 32'h0,         STAT_DONE);
        add_row(OP_ALLOC,   17'd40000, 32'h0,         0, 32'h0,         STAT_DONE);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            tg.addr = dir_rows[r].exp_addr;
            tg.status = dir_rows[r].exp_status;
            send_request(dir_rows[r].op, dir_rows[r].size, dir_rows[r].addr,
                         dir_rows[r].typed, tg);
        end

        // The heap is kept across base changes, so old blocks follow the new
        // base; the near-top base makes payload addresses wrap.
        bases = '{32'h0000_0000, 32'hFFFF_FFF0, $urandom(), 32'hFFFF_FFFF};
        idle_pcts = '{0, 85, 0, 23};
        stall_pcts = '{0, 0, 85, 23};
        tg = '{addr: '0, status: STAT_DONE};
        for (int p = 0; p < 4; p++) begin
            drain_and_configure(bases[p]);
            sender_idle_pct = idle_pcts[p];
            recv_stall_pct = stall_pcts[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(99) < 48) ? OP_RELEASE : OP_ALLOC;
                if (op == OP_ALLOC)
                    send_request(op, random_size(), $urandom(), 0, tg);
                else
                    send_request(op, 17'($urandom()), random_release_addr(), 0, tg);
            end
        end
        drain_and_configure(32'h0010_0000);
        recv_stall_pct = 0;
        for (int n = 0; n < 20; n++)
            send_request(1'($urandom_range(1)), random_size(), random_release_addr(), 0, tg);

        req_if.valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_grants.size() == 0) begin
            $display("tb_first_fit_heap_allocator_core OK");
        end else begin
            $display("tb_first_fit_heap_allocator_core NOT OK");
        end
        $finish;
    end

endmodule
